[src/vpa_pkg.sv]
package vpa_pkg;

    parameter int TOTAL_KB          = 1024;
    parameter int MAX_ENTRIES       = 32;
    parameter int MAX_OWNER         = 256;
    parameter int FIRST_VALID_OWNER = 3;

    parameter int IDX_W   = $clog2(MAX_ENTRIES);
    parameter int CNT_W   = $clog2(MAX_ENTRIES + 1);
    parameter int KB_W    = 11;
    parameter int ADDR_W  = 10;
    parameter int OWNER_W = 8;
    parameter int MODE_W  = 2;
    parameter int NFREE_W = 6;

    parameter logic [KB_W-1:0]   TOTAL_KB_V = KB_W'(TOTAL_KB);
    parameter logic [CNT_W-1:0]  MAX_ENTRIES_V = CNT_W'(MAX_ENTRIES);

    parameter logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    parameter logic [MODE_W-1:0] MODE_BEST  = 2'd1;

    typedef enum logic [1:0] {
        CMD_CLAIM   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_PACK    = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_BAD_OWNER = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t                command;
        logic [OWNER_W-1:0]  owner_id;
        logic [KB_W-1:0]     request_kb;
    } req_word_t;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   alloc_base;
        logic [KB_W-1:0]     freed_kb;
        logic [KB_W-1:0]     free_total;
        logic [KB_W-1:0]     largest_free;
        logic [NFREE_W-1:0]  free_block_count;
    } rsp_word_t;

    typedef struct packed {
        logic [KB_W-1:0]    base;
        logic [KB_W-1:0]    size;
        logic [OWNER_W-1:0] owner;
        logic               is_free;
    } entry_t;

    typedef enum logic [2:0] {
        OP_IDENT,
        OP_SCAN,
        OP_ALLOC,
        OP_FREE,
        OP_COMPACT
    } pass_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_DONE,
        S_COPY_RD,
        S_COPY_EV,
        S_COPY_HOLD,
        S_TAIL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic scan_ev;
        logic scan_done;
        logic copy_ev;
        logic hold_wr;
        logic tail_wr;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_needed;
        logic pass_end;
        logic need_hold;
        logic out_ready;
    } dp_stat_t;

endpackage

[src/vpa_datapath.sv]
module vpa_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  vpa_pkg::ctrl_cmd_t            ctl,
    output vpa_pkg::dp_stat_t             st,
    input  vpa_pkg::req_word_t            req_word,
    input  logic                          mode_we,
    input  logic [vpa_pkg::MODE_W-1:0]    mode_wdata,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output vpa_pkg::rsp_word_t            rsp_word
);

    // Two banks: every copy pass reads the live bank and writes the other one.
    vpa_pkg::entry_t mem [2 * vpa_pkg::MAX_ENTRIES];

    logic                           bank_reg, bank_next;
    logic                           fresh_reg, fresh_next;
    logic [vpa_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [vpa_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic                           rsp_valid_reg, rsp_valid_next;

    vpa_pkg::entry_t                rd_data_reg;
    vpa_pkg::pass_op_t              op_reg, op_next;
    vpa_pkg::status_t               status_reg, status_next;
    logic [vpa_pkg::OWNER_W-1:0]    owner_reg, owner_next;
    logic [vpa_pkg::KB_W-1:0]       req_reg, req_next;
    logic [vpa_pkg::CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [vpa_pkg::CNT_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                           pick_v_reg, pick_v_next;
    logic [vpa_pkg::IDX_W-1:0]      pick_idx_reg, pick_idx_next;
    logic [vpa_pkg::KB_W-1:0]       pick_size_reg, pick_size_next;
    logic                           pend_v_reg, pend_v_next;
    logic [vpa_pkg::KB_W-1:0]       pend_base_reg, pend_base_next;
    logic [vpa_pkg::KB_W-1:0]       pend_size_reg, pend_size_next;
    logic [vpa_pkg::KB_W-1:0]       next_base_reg, next_base_next;
    vpa_pkg::entry_t                hold_reg, hold_next;
    logic [vpa_pkg::KB_W-1:0]       total_reg, total_next;
    logic [vpa_pkg::KB_W-1:0]       largest_reg, largest_next;
    logic [vpa_pkg::NFREE_W-1:0]    nfree_reg, nfree_next;
    logic [vpa_pkg::KB_W-1:0]       freed_reg, freed_next;
    logic [vpa_pkg::ADDR_W-1:0]     abase_reg, abase_next;
    vpa_pkg::rsp_word_t             rsp_word_reg, rsp_word_next;

    vpa_pkg::entry_t                e_mod;
    vpa_pkg::entry_t                wr_data;
    vpa_pkg::entry_t                tail_entry;
    vpa_pkg::entry_t                reset_entry;
    logic                           wr_en;
    logic                           matched;
    logic                           need_hold;
    logic                           tail_needed;
    logic                           candidate;
    logic                           owner_ok;
    logic                           out_ready;

    always_comb
    begin
        reset_entry         = '0;
        reset_entry.size    = vpa_pkg::TOTAL_KB_V;
        reset_entry.is_free = 1'b1;
    end

    assign owner_ok = (req_word.owner_id >= vpa_pkg::OWNER_W'(vpa_pkg::FIRST_VALID_OWNER))
                   && ({1'b0, req_word.owner_id} < 9'(vpa_pkg::MAX_OWNER));

    assign out_ready = !rsp_valid_reg || !rsp_stall;

    // Tail written at the end of a pass: the pending merged block of a free,
    // or the single free block that closes a compaction.
    always_comb
    begin
        tail_entry  = '0;
        tail_needed = 1'b0;
        case (op_reg)
            vpa_pkg::OP_FREE:
            begin
                tail_needed        = pend_v_reg;
                tail_entry.base    = pend_base_reg;
                tail_entry.size    = pend_size_reg;
                tail_entry.is_free = 1'b1;
            end
            vpa_pkg::OP_COMPACT:
            begin
                tail_needed        = (next_base_reg < vpa_pkg::TOTAL_KB_V)
                                  && (wr_idx_reg < vpa_pkg::MAX_ENTRIES_V);
                tail_entry.base    = next_base_reg;
                tail_entry.size    = vpa_pkg::TOTAL_KB_V - next_base_reg;
                tail_entry.is_free = 1'b1;
            end
            default:
            begin
                tail_needed = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        e_mod   = rd_data_reg;
        matched = (op_reg == vpa_pkg::OP_FREE) && !rd_data_reg.is_free
               && (rd_data_reg.owner == owner_reg);
        if (matched)
        begin
            e_mod.is_free = 1'b1;
            e_mod.owner   = '0;
        end
    end

    always_comb
    begin
        bank_next      = bank_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        mode_next      = mode_we ? mode_wdata : mode_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        owner_next     = owner_reg;
        req_next       = req_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pick_v_next    = pick_v_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        pend_v_next    = pend_v_reg;
        pend_base_next = pend_base_reg;
        pend_size_next = pend_size_reg;
        next_base_next = next_base_reg;
        hold_next      = hold_reg;
        total_next     = total_reg;
        largest_next   = largest_reg;
        nfree_next     = nfree_reg;
        freed_next     = freed_reg;
        abase_next     = abase_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_data        = rd_data_reg;
        need_hold      = 1'b0;
        candidate      = rd_data_reg.is_free && (rd_data_reg.size >= req_reg);

        if (ctl.start)
        begin
            owner_next     = req_word.owner_id;
            req_next       = req_word.request_kb;
            rd_idx_next    = '0;
            wr_idx_next    = '0;
            pick_v_next    = 1'b0;
            pend_v_next    = 1'b0;
            next_base_next = '0;
            total_next     = '0;
            largest_next   = '0;
            nfree_next     = '0;
            freed_next     = '0;
            abase_next     = '0;
            status_next    = vpa_pkg::ST_OK;
            op_next        = vpa_pkg::OP_IDENT;
            case (req_word.command)
                vpa_pkg::CMD_CLAIM:
                begin
                    if (!owner_ok)
                    begin
                        status_next = vpa_pkg::ST_BAD_OWNER;
                    end
                    else if (req_word.request_kb == '0
                             || req_word.request_kb > vpa_pkg::TOTAL_KB_V)
                    begin
                        status_next = vpa_pkg::ST_BAD_SIZE;
                    end
                    else
                    begin
                        op_next = vpa_pkg::OP_SCAN;
                    end
                end
                vpa_pkg::CMD_FREE:
                begin
                    if (!owner_ok)
                    begin
                        status_next = vpa_pkg::ST_BAD_OWNER;
                    end
                    else
                    begin
                        op_next = vpa_pkg::OP_FREE;
                    end
                end
                vpa_pkg::CMD_PACK:
                begin
                    op_next = vpa_pkg::OP_COMPACT;
                end
                default:
                begin
                    op_next = vpa_pkg::OP_IDENT;
                end
            endcase
        end

        // Fit search: ties keep the lower entry, so only strict compares replace.
        if (ctl.scan_ev)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            if (candidate)
            begin
                if ((!pick_v_reg)
                    || (mode_reg == vpa_pkg::MODE_BEST && rd_data_reg.size < pick_size_reg)
                    || (mode_reg != vpa_pkg::MODE_BEST && mode_reg != vpa_pkg::MODE_FIRST
                        && rd_data_reg.size > pick_size_reg))
                begin
                    pick_v_next    = 1'b1;
                    pick_idx_next  = rd_idx_reg[vpa_pkg::IDX_W-1:0];
                    pick_size_next = rd_data_reg.size;
                end
            end
        end

        if (ctl.scan_done)
        begin
            rd_idx_next = '0;
            if (!pick_v_reg)
            begin
                status_next = vpa_pkg::ST_NO_FIT;
                op_next     = vpa_pkg::OP_IDENT;
            end
            else if (pick_size_reg != req_reg && count_reg >= vpa_pkg::MAX_ENTRIES_V)
            begin
                status_next = vpa_pkg::ST_FULL;
                op_next     = vpa_pkg::OP_IDENT;
            end
            else
            begin
                op_next = vpa_pkg::OP_ALLOC;
            end
        end

        if (ctl.copy_ev)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            case (op_reg)
                vpa_pkg::OP_ALLOC:
                begin
                    wr_en = 1'b1;
                    if (rd_idx_reg == {1'b0, pick_idx_reg})
                    begin
                        abase_next       = rd_data_reg.base[vpa_pkg::ADDR_W-1:0];
                        wr_data.is_free  = 1'b0;
                        wr_data.owner    = owner_reg;
                        if (rd_data_reg.size != req_reg)
                        begin
                            wr_data.size      = req_reg;
                            need_hold         = 1'b1;
                            hold_next.base    = rd_data_reg.base + req_reg;
                            hold_next.size    = rd_data_reg.size - req_reg;
                            hold_next.owner   = '0;
                            hold_next.is_free = 1'b1;
                        end
                    end
                end
                vpa_pkg::OP_FREE:
                begin
                    if (matched)
                    begin
                        freed_next = freed_reg + rd_data_reg.size;
                    end
                    if (e_mod.is_free)
                    begin
                        pend_v_next = 1'b1;
                        if (pend_v_reg)
                        begin
                            pend_size_next = pend_size_reg + e_mod.size;
                        end
                        else
                        begin
                            pend_base_next = e_mod.base;
                            pend_size_next = e_mod.size;
                        end
                    end
                    else if (pend_v_reg)
                    begin
                        // Close the merged free run first; this block follows it.
                        wr_en           = 1'b1;
                        wr_data         = '0;
                        wr_data.base    = pend_base_reg;
                        wr_data.size    = pend_size_reg;
                        wr_data.is_free = 1'b1;
                        pend_v_next     = 1'b0;
                        need_hold       = 1'b1;
                        hold_next       = e_mod;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = e_mod;
                    end
                end
                vpa_pkg::OP_COMPACT:
                begin
                    if (!rd_data_reg.is_free)
                    begin
                        wr_en          = 1'b1;
                        wr_data.base   = next_base_reg;
                        next_base_next = next_base_reg + rd_data_reg.size;
                    end
                end
                default:
                begin
                    wr_en = 1'b1;
                end
            endcase
        end

        if (ctl.hold_wr)
        begin
            wr_en   = 1'b1;
            wr_data = hold_reg;
        end

        if (ctl.tail_wr)
        begin
            wr_en      = tail_needed;
            wr_data    = tail_entry;
            bank_next  = !bank_reg;
            fresh_next = 1'b0;
            count_next = wr_idx_reg + {{(vpa_pkg::CNT_W-1){1'b0}}, tail_needed};
        end

        if (wr_en)
        begin
            wr_idx_next = wr_idx_reg + 1'b1;
            if (wr_data.is_free)
            begin
                total_next = total_reg + wr_data.size;
                nfree_next = nfree_reg + 1'b1;
                if (wr_data.size > largest_reg)
                begin
                    largest_next = wr_data.size;
                end
            end
        end

        if (ctl.finish && out_ready)
        begin
            rsp_valid_next                 = 1'b1;
            rsp_word_next.status           = status_reg;
            rsp_word_next.alloc_base       = (status_reg == vpa_pkg::ST_OK) ? abase_reg : '0;
            rsp_word_next.freed_kb         = freed_reg;
            rsp_word_next.free_total       = total_reg;
            rsp_word_next.largest_free     = largest_reg;
            rsp_word_next.free_block_count = nfree_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= fresh_reg ? reset_entry
                                 : mem[{bank_reg, rd_idx_reg[vpa_pkg::IDX_W-1:0]}];
        if (wr_en)
        begin
            mem[{!bank_reg, wr_idx_reg[vpa_pkg::IDX_W-1:0]}] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= 1'b0;
            fresh_reg     <= 1'b1;
            count_reg     <= vpa_pkg::CNT_W'(1);
            mode_reg      <= vpa_pkg::MODE_FIRST;
            rsp_valid_reg <= 1'b0;
            op_reg        <= vpa_pkg::OP_IDENT;
        end
        else
        begin
            bank_reg      <= bank_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            rsp_valid_reg <= rsp_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        owner_reg     <= owner_next;
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        pick_v_reg    <= pick_v_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
        pend_v_reg    <= pend_v_next;
        pend_base_reg <= pend_base_next;
        pend_size_reg <= pend_size_next;
        next_base_reg <= next_base_next;
        hold_reg      <= hold_next;
        total_reg     <= total_next;
        largest_reg   <= largest_next;
        nfree_reg     <= nfree_next;
        freed_reg     <= freed_next;
        abase_reg     <= abase_next;
        rsp_word_reg  <= rsp_word_next;
    end

    assign st.scan_needed = (op_reg == vpa_pkg::OP_SCAN);
    assign st.pass_end    = (rd_idx_reg == count_reg);
    assign st.need_hold   = need_hold;
    assign st.out_ready   = out_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

[src/vpa_controller.sv]
module vpa_controller
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  vpa_pkg::dp_stat_t  st,
    output vpa_pkg::ctrl_cmd_t ctl
);

    vpa_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vpa_pkg::S_IDLE:      state_next = req_valid ? vpa_pkg::S_PREP : vpa_pkg::S_IDLE;
            vpa_pkg::S_PREP:      state_next = st.scan_needed ? vpa_pkg::S_SCAN_RD
                                                              : vpa_pkg::S_COPY_RD;
            vpa_pkg::S_SCAN_RD:   state_next = st.pass_end ? vpa_pkg::S_SCAN_DONE
                                                           : vpa_pkg::S_SCAN_EV;
            vpa_pkg::S_SCAN_EV:   state_next = vpa_pkg::S_SCAN_RD;
            vpa_pkg::S_SCAN_DONE: state_next = vpa_pkg::S_COPY_RD;
            vpa_pkg::S_COPY_RD:   state_next = st.pass_end ? vpa_pkg::S_TAIL
                                                           : vpa_pkg::S_COPY_EV;
            vpa_pkg::S_COPY_EV:   state_next = st.need_hold ? vpa_pkg::S_COPY_HOLD
                                                            : vpa_pkg::S_COPY_RD;
            vpa_pkg::S_COPY_HOLD: state_next = vpa_pkg::S_COPY_RD;
            vpa_pkg::S_TAIL:      state_next = vpa_pkg::S_FINISH;
            vpa_pkg::S_FINISH:    state_next = st.out_ready ? vpa_pkg::S_IDLE
                                                            : vpa_pkg::S_FINISH;
            default:              state_next = vpa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        req_stall = (state_reg != vpa_pkg::S_IDLE);
        case (state_reg)
            vpa_pkg::S_IDLE:      ctl.start     = req_valid;
            vpa_pkg::S_SCAN_EV:   ctl.scan_ev   = 1'b1;
            vpa_pkg::S_SCAN_DONE: ctl.scan_done = 1'b1;
            vpa_pkg::S_COPY_EV:   ctl.copy_ev   = 1'b1;
            vpa_pkg::S_COPY_HOLD: ctl.hold_wr   = 1'b1;
            vpa_pkg::S_TAIL:      ctl.tail_wr   = 1'b1;
            vpa_pkg::S_FINISH:    ctl.finish    = 1'b1;
            default:              ctl           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/variable_partition_allocator_unit.sv]
// Variable partition allocator: a table of up to 32 address-ordered blocks
// over 1024 KB, taking alloc, free-owner, compact and status commands.
// Request channel: req_valid, req_stall, req_word; a word is taken when
// req_valid is high and req_stall is low. Response channel: rsp_valid,
// rsp_stall, rsp_word, one response word per request word.
// The fit policy register is written through mode_we and mode_wdata;
// the user must do so while the block is idle; the block does not enforce it.
// One command is handled at a time. Each command makes one copy pass over
// the n table entries into the second bank, with an extra hold write for
// each block split off or freed run closed; an alloc first makes a fit
// search pass over the same entries.
// The response sits in an output register, so a stalled receiver only holds
// the next request back once a second response is ready.
// After reset the table holds one free block covering all memory and the
// policy is first fit; no clearing pass is needed.
module variable_partition_allocator_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  vpa_pkg::req_word_t            req_word,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output vpa_pkg::rsp_word_t            rsp_word,
    input  logic                          mode_we,
    input  logic [vpa_pkg::MODE_W-1:0]    mode_wdata
);

    vpa_pkg::ctrl_cmd_t ctl;
    vpa_pkg::dp_stat_t  st;

    vpa_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .ctl       (ctl)
    );

    vpa_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .st         (st),
        .req_word   (req_word),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word)
    );

endmodule

[src/vpa_checker.sv]
module vpa_assertions
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input vpa_pkg::rsp_word_t rsp_word
);

    // A taken request word keeps the block busy in the following cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous still in work");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
        else $error("stalled response word changed");

    a_largest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.largest_free <= rsp_word.free_total
                       && rsp_word.free_total <= vpa_pkg::TOTAL_KB_V))
        else $error("free space figures inconsistent");

    a_count_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_word.free_block_count == '0) == (rsp_word.free_total == '0)))
        else $error("free block count disagrees with free total");

endmodule

bind variable_partition_allocator_unit vpa_assertions u_vpa_assertions
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
